### rtl/kpr_pkg.sv
// Package for the keyframe path resampler.
// Holds the fixed coordinate widths, register indexes and reset values.
// No dependencies.
package kpr_pkg;

  localparam int CW = 32;          // coordinate width
  localparam int DW = CW + 1;      // width of an axis difference
  localparam int SQ_W = 61;        // root working width
  localparam int ROOT_ITERS = 30;  // result bits of the root
  localparam int ACC_W = 32;       // ceiling accumulator width
  localparam int REG_W = 22;       // widest register
  localparam int IDX_W = 2;

  localparam logic [63:0] BIG_DIFF = 64'd1 << 29;

  localparam logic [IDX_W-1:0] REG_STRIDE = 2'd0;
  localparam logic [IDX_W-1:0] REG_RES    = 2'd1;
  localparam logic [IDX_W-1:0] REG_PASS   = 2'd2;

  localparam logic [7:0]  STRIDE_RST = 8'd3;
  localparam logic [21:0] RES_RST    = 22'd16384;

endpackage

### rtl/kpr_if.sv
// Stream interfaces for path points in and resampled points out.
// Depends on kpr_pkg.
interface kpr_in_if
  import kpr_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;
  logic                 is_last;

  modport source (output valid, pos_x, pos_y, pos_z, is_last, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, is_last, output ready);
endinterface

interface kpr_out_if
  import kpr_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic                 run_last;
  logic                 path_end;
  logic                 steps_clamped;

  modport source (output valid, out_x, out_y, out_z, run_last, path_end, steps_clamped,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, run_last, path_end, steps_clamped,
                  output ready);
endinterface

### rtl/kpr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the resampler top level.
module kpr_div #(
  parameter int DVD_W = 33,
  parameter int DVS_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quo,
  output logic [DVS_W-1:0] rem
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   sh;
  logic             fits;

  assign sh   = {rem_r, quo_r[DVD_W-1]};
  assign fits = (sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
        quo_r  <= dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? DVS_W'(sh - {1'b0, divisor}) : sh[DVS_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

### rtl/keyframe_path_resampler.sv
// Top level of the keyframe path resampler.
// Depends on kpr_pkg, the kpr_in_if / kpr_out_if interfaces and kpr_div.
//
// The block takes one path point per request and keeps as keyframes the first
// point, the last point and every point whose index is a multiple of the stride.
// Each new keyframe closes a segment from the held one; the segment length is a
// floor integer square root, the step count is max(2, ceil(length/resolution))
// saturated at MAX_STEPS, and the segment is emitted as evenly spaced points
// rounded to nearest, both ends included. A point that closes no segment
// produces nothing. A segment passes through accept, difference and squaring,
// root, ceiling search and three divisions on the shared serial divider, one
// per axis, and then emits one point per cycle while the output is not
// stalled; a segment with a very large axis difference skips the squaring, the
// root and the search. In pass-through mode each point is echoed unchanged.
// The input is not ready while a segment is in work.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
module keyframe_path_resampler
  import kpr_pkg::*;
#(
  parameter int MAX_STEPS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  kpr_in_if.sink           in_pt,
  kpr_out_if.source        out_pt,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_addr,
  input  logic [REG_W-1:0] cfg_data
);

  localparam int SW = $clog2(MAX_STEPS + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PASS = 4'd1;
  localparam logic [3:0] ST_DIFF = 4'd2;
  localparam logic [3:0] ST_SQ   = 4'd3;
  localparam logic [3:0] ST_SQRT = 4'd4;
  localparam logic [3:0] ST_CEIL = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_EMIT = 4'd7;

  // Configuration registers.
  logic [7:0]       stride_r;
  logic [REG_W-1:0] res_r;
  logic             pass_r;
  logic [7:0]       stride_eff;
  logic [REG_W-1:0] res_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= STRIDE_RST;
      res_r    <= RES_RST;
      pass_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STRIDE: stride_r <= cfg_data[7:0];
        REG_RES:    res_r    <= cfg_data;
        REG_PASS:   pass_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign stride_eff = (stride_r == 8'd0) ? 8'd1 : stride_r;
  assign res_eff    = (res_r == '0) ? REG_W'(1) : res_r;

  // Path state and segment working registers.
  logic [3:0]           state_r;
  logic                 have_key_r;
  logic [7:0]           phase_r;
  logic signed [CW-1:0] a_r [3];
  logic signed [CW-1:0] b_r [3];
  logic                 last_r;
  logic [DW-1:0]        mag_r [3];
  logic                 neg_r [3];
  logic [1:0]           idx_r;
  logic [57:0]          mult_r;
  logic [SQ_W-1:0]      sum_r;
  logic [SQ_W-1:0]      v_r;
  logic [SQ_W-1:0]      root_r;
  logic [SQ_W-1:0]      bit_r;
  logic [4:0]           iter_r;
  logic [ACC_W-1:0]     acc_r;
  logic [SW-1:0]        k_r;
  logic [SW-1:0]        steps_r;
  logic                 clamp_r;
  logic                 div_wait_r;
  logic [DW-1:0]        qd_r [3];
  logic [SW:0]          rd_r [3];
  logic [DW-1:0]        q_r [3];
  logic [SW:0]          r_r [3];
  logic [SW-1:0]        s_r;

  // Output register.
  logic                 out_valid_r;
  logic signed [CW-1:0] o_r [3];
  logic                 o_run_r;
  logic                 o_end_r;
  logic                 o_clamp_r;

  logic          accept;
  logic          slot_free;
  logic          out_load;
  logic          is_kf;
  logic [7:0]    phase_inc;
  logic [7:0]    phase_nxt;
  logic [SW-1:0] n_w;
  logic [SW:0]   two_n;
  logic          emit_final;
  logic [SQ_W-1:0] trial;
  logic [ACC_W-1:0] dist_w;

  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_quo;
  logic [SW-1:0] div_rem;

  assign in_pt.ready = (state_r == ST_IDLE);
  assign accept      = in_pt.valid && in_pt.ready;
  assign slot_free   = !out_valid_r || out_pt.ready;
  // The output register takes a new point in this cycle.
  assign out_load    = slot_free && (state_r == ST_PASS || state_r == ST_EMIT);
  assign is_kf       = !have_key_r || in_pt.is_last || (phase_r == 8'd0);
  assign phase_inc   = phase_r + 8'd1;
  assign phase_nxt   = (in_pt.is_last || phase_inc >= stride_eff) ? 8'd0 : phase_inc;
  assign n_w         = steps_r - 1'b1;
  assign two_n       = {n_w, 1'b0};
  assign emit_final  = (s_r == n_w);
  assign trial       = root_r + bit_r;
  assign dist_w      = ACC_W'(root_r[ROOT_ITERS-1:0]);
  assign div_start   = (state_r == ST_DIV) && !div_wait_r;

  kpr_div #(
    .DVD_W (DW),
    .DVS_W (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_r[idx_r]),
    .divisor  (n_w),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Difference of one axis, b minus a, with sign and magnitude.
  function automatic logic [DW:0] axis_diff(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b);
    logic [DW-1:0] d;
    logic [DW-1:0] m;
    begin
      d = {b[CW-1], b} - {a[CW-1], a};
      m = d[DW-1] ? (~d + 1'b1) : d;
      axis_diff = {d[DW-1], m};
    end
  endfunction

  always_ff @(posedge clk) begin
    logic [DW:0]   dm;
    logic          big;
    logic [SW+1:0] t;
    logic [DW-1:0] off;
    logic [DW-1:0] pt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_key_r  <= 1'b0;
      phase_r     <= 8'd0;
      out_valid_r <= 1'b0;
      div_wait_r  <= 1'b0;
      for (int i = 0; i < 3; i++) a_r[i] <= '0;
    end else begin
      if (out_valid_r && out_pt.ready && !out_load) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            last_r <= in_pt.is_last;
            b_r[0] <= in_pt.pos_x;
            b_r[1] <= in_pt.pos_y;
            b_r[2] <= in_pt.pos_z;
            if (pass_r) begin
              have_key_r <= 1'b0;
              phase_r    <= 8'd0;
              state_r    <= ST_PASS;
            end else begin
              phase_r <= phase_nxt;
              if (is_kf) begin
                have_key_r <= !in_pt.is_last;
                if (have_key_r) begin
                  state_r <= ST_DIFF;
                end else begin
                  a_r[0] <= in_pt.pos_x;
                  a_r[1] <= in_pt.pos_y;
                  a_r[2] <= in_pt.pos_z;
                end
              end
            end
          end
        end
        ST_PASS: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            for (int i = 0; i < 3; i++) o_r[i] <= b_r[i];
            o_run_r   <= 1'b1;
            o_end_r   <= last_r;
            o_clamp_r <= 1'b0;
            state_r   <= ST_IDLE;
          end
        end
        ST_DIFF: begin
          big = 1'b0;
          for (int i = 0; i < 3; i++) begin
            dm = axis_diff(a_r[i], b_r[i]);
            neg_r[i] <= dm[DW];
            mag_r[i] <= dm[DW-1:0];
            if (64'(dm[DW-1:0]) >= BIG_DIFF) big = 1'b1;
          end
          idx_r <= 2'd0;
          sum_r <= '0;
          if (big) begin
            clamp_r <= 1'b1;
            steps_r <= SW'(MAX_STEPS);
            state_r <= ST_DIV;
          end else begin
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          // Square one axis per cycle; the sum adds each product in the cycle after the multiplier forms it.
          // Magnitudes here are below 2^29, so a 29 by 29 bit product suffices.
          if (idx_r != 2'd3) begin
            mult_r <= 58'(mag_r[idx_r][28:0]) * 58'(mag_r[idx_r][28:0]);
          end
          if (idx_r != 2'd0) sum_r <= sum_r + SQ_W'(mult_r);
          if (idx_r == 2'd3) begin
            v_r     <= sum_r + SQ_W'(mult_r);
            root_r  <= '0;
            bit_r   <= SQ_W'(1) << 58;
            iter_r  <= '0;
            state_r <= ST_SQRT;
          end
          idx_r <= idx_r + 2'd1;
        end
        ST_SQRT: begin
          if (v_r >= trial) begin
            v_r    <= v_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r  <= bit_r >> 2;
          iter_r <= iter_r + 5'd1;
          if (iter_r == 5'(ROOT_ITERS - 1)) begin
            acc_r   <= '0;
            k_r     <= '0;
            state_r <= ST_CEIL;
          end
        end
        ST_CEIL: begin
          idx_r <= 2'd0;
          if (acc_r >= dist_w) begin
            steps_r <= (k_r < SW'(2)) ? SW'(2) : k_r;
            clamp_r <= 1'b0;
            state_r <= ST_DIV;
          end else if (k_r == SW'(MAX_STEPS)) begin
            steps_r <= SW'(MAX_STEPS);
            clamp_r <= 1'b1;
            state_r <= ST_DIV;
          end else begin
            acc_r <= acc_r + ACC_W'(res_eff);
            k_r   <= k_r + 1'b1;
          end
        end
        ST_DIV: begin
          if (div_start) div_wait_r <= 1'b1;
          if (div_done) begin
            div_wait_r   <= 1'b0;
            qd_r[idx_r]  <= div_quo;
            rd_r[idx_r]  <= {div_rem, 1'b0};
            q_r[idx_r]   <= '0;
            r_r[idx_r]   <= (SW+1)'(n_w);
            idx_r        <= idx_r + 2'd1;
            if (idx_r == 2'd2) begin
              s_r     <= '0;
              state_r <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              off    = neg_r[i] ? (~q_r[i] + 1'b1) : q_r[i];
              pt     = {a_r[i][CW-1], a_r[i]} + off;
              o_r[i] <= pt[CW-1:0];
              // Step the rounded quotient by m/n and carry the remainder.
              t = {1'b0, r_r[i]} + {1'b0, rd_r[i]};
              if (t >= {1'b0, two_n}) begin
                r_r[i] <= (SW+1)'(t - {1'b0, two_n});
                q_r[i] <= q_r[i] + qd_r[i] + 1'b1;
              end else begin
                r_r[i] <= t[SW:0];
                q_r[i] <= q_r[i] + qd_r[i];
              end
            end
            o_run_r   <= emit_final;
            o_end_r   <= emit_final && last_r;
            o_clamp_r <= clamp_r;
            s_r       <= s_r + 1'b1;
            if (emit_final) begin
              for (int i = 0; i < 3; i++) a_r[i] <= b_r[i];
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_pt.valid         = out_valid_r;
  assign out_pt.out_x         = o_r[0];
  assign out_pt.out_y         = o_r[1];
  assign out_pt.out_z         = o_r[2];
  assign out_pt.run_last      = o_run_r;
  assign out_pt.path_end      = o_end_r;
  assign out_pt.steps_clamped = o_clamp_r;

  // A saturated segment always runs the full step count.
  a_clamp_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && clamp_r) |-> (steps_r == SW'(MAX_STEPS)))
    else $error("clamped segment without full step count");

  // The last sample of a segment lands exactly on the new keyframe.
  a_end_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && slot_free && emit_final) |->
      (q_r[0] == mag_r[0] && q_r[1] == mag_r[1] && q_r[2] == mag_r[2]))
    else $error("segment end does not reach keyframe");

  // The rounding remainder stays below twice the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (r_r[0] < two_n && r_r[1] < two_n && r_r[2] < two_n))
    else $error("rounding remainder out of range");

  // No input request is taken while a segment is in its divide or emit state.
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT || state_r == ST_DIV) |-> !in_pt.ready)
    else $error("input taken during segment");

endmodule
